### src/sebe_pkg.sv
// ----------------------------------------------------------------------------
// sebe_pkg
// shared types and constants of the sound event byte-code encoder
// ----------------------------------------------------------------------------
package sebe_pkg;

  // default widths and sizes
  localparam int GAP_WIDTH_DEF   = 11;
  localparam int QUEUE_DEPTH_DEF = 4;

  // event actions
  localparam logic [3:0] ACT_NOTE_ON    = 4'd0;
  localparam logic [3:0] ACT_NOTE_OFF   = 4'd1;
  localparam logic [3:0] ACT_SET_NOTE   = 4'd2;
  localparam logic [3:0] ACT_SET_FREQ   = 4'd3;
  localparam logic [3:0] ACT_VOLUME     = 4'd4;
  localparam logic [3:0] ACT_PAN        = 4'd5;
  localparam logic [3:0] ACT_INSTR      = 4'd6;
  localparam logic [3:0] ACT_REG        = 4'd7;
  localparam logic [3:0] ACT_FLAGS      = 4'd8;
  localparam logic [3:0] ACT_LOCK       = 4'd9;
  localparam logic [3:0] ACT_LOOP       = 4'd10;
  localparam logic [3:0] ACT_TEMPO      = 4'd11;
  localparam logic [3:0] ACT_DELAY_ONLY = 4'd12;
  localparam logic [3:0] ACT_END        = 4'd13;

  // stream byte codes
  localparam logic [7:0] BYTE_NOTE_OFF  = 8'h10;
  localparam logic [7:0] BYTE_VOLUME    = 8'h20;
  localparam logic [7:0] BYTE_SET_CH    = 8'h30;
  localparam logic [7:0] BYTE_INSTR     = 8'h40;
  localparam logic [7:0] BYTE_NOTE_HI   = 8'h80;
  localparam logic [7:0] BYTE_DLY_SHORT = 8'hD0;
  localparam logic [7:0] BYTE_LOCK      = 8'hE0;
  localparam logic [7:0] BYTE_PAN       = 8'hF0;
  localparam logic [7:0] BYTE_REG       = 8'hF8;
  localparam logic [7:0] BYTE_FLAG_SET  = 8'hFA;
  localparam logic [7:0] BYTE_FLAG_CLR  = 8'hFB;
  localparam logic [7:0] BYTE_END_LOOP  = 8'hFC;
  localparam logic [7:0] BYTE_LOOP      = 8'hFD;
  localparam logic [7:0] BYTE_DLY_LONG  = 8'hFE;
  localparam logic [7:0] BYTE_FF        = 8'hFF;

  localparam logic [7:0]  TEMPO_RESET  = 8'd128;
  localparam int          DLY_SHORT_MAX = 16;
  localparam int          DLY_RUN       = 255;
  // ceil(2^19 / 12): exact quotient by 12 for any 16-bit value
  localparam logic [15:0] RECIP_12     = 16'd43691;
  localparam int          RECIP_SHIFT  = 19;

  // command bytes of one event, sent in order b0, b1, b2
  typedef struct packed {
    logic [1:0] cnt;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } sebe_cmd_t;

endpackage

### src/sebe_front.sv
// ----------------------------------------------------------------------------
// sebe_front
// takes events, scales the time gap by tempo and builds the command bytes
// ----------------------------------------------------------------------------
module sebe_front #(
  parameter int GAP_WIDTH = sebe_pkg::GAP_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_push,
  output logic                  in_full,
  input  logic [3:0]            in_action,
  input  logic [GAP_WIDTH-1:0]  in_time_gap,
  input  logic [8:0]            in_channel,
  input  logic [15:0]           in_value,
  output logic                  q_push,
  input  logic                  q_full,
  output logic [GAP_WIDTH:0]    q_delay,
  output sebe_pkg::sebe_cmd_t   q_cmd
);
  import sebe_pkg::*;

  localparam int PROD_W = GAP_WIDTH + 8;

  logic               accept;
  logic               advance;
  logic [PROD_W-1:0]  gap_prod;
  logic [31:0]        quo_prod;
  logic [7:0]         rem_sum;
  logic [3:0]         rmd;
  logic [7:0]         ch8;
  logic [7:0]         v8;
  logic               ch_le7;
  logic               ch_le10;
  sebe_cmd_t          cmd;

  logic               s1_valid_r;
  logic [3:0]         s1_action_r;
  logic [8:0]         s1_chan_r;
  logic [15:0]        s1_value_r;
  logic [PROD_W-1:0]  s1_prod_r;
  logic [3:0]         s1_quo_r;
  logic               s1_loop_r;
  logic [7:0]         tempo_r;
  logic [7:0]         tempo_nxt;
  logic               loop_r;
  logic [6:0]         rem_r;

  assign accept   = in_push & ~in_full;
  assign advance  = s1_valid_r & ~q_full;
  assign in_full  = s1_valid_r & q_full;

  // gap scaling and note quotient, both taken straight from the ports
  assign gap_prod = PROD_W'(in_time_gap) * PROD_W'(tempo_r);
  assign quo_prod = 32'(in_value) * 32'(RECIP_12);

  assign tempo_nxt = (in_value[15:8] != 8'd0) ? BYTE_FF : in_value[7:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
      tempo_r    <= TEMPO_RESET;
      loop_r     <= 1'b0;
      rem_r      <= 7'd0;
    end else begin
      if (accept) begin
        s1_valid_r <= 1'b1;
      end else if (advance) begin
        s1_valid_r <= 1'b0;
      end
      if (accept && in_action == ACT_TEMPO) begin
        tempo_r <= tempo_nxt;
      end
      if (accept && in_action == ACT_LOOP) begin
        loop_r <= 1'b1;
      end
      if (advance) begin
        rem_r <= rem_sum[6:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_action_r <= in_action;
      s1_chan_r   <= in_channel;
      s1_value_r  <= in_value;
      s1_prod_r   <= gap_prod;
      s1_quo_r    <= quo_prod[RECIP_SHIFT+3:RECIP_SHIFT];
      s1_loop_r   <= loop_r;
    end
  end

  // delay with carried fraction
  assign rem_sum = {1'b0, rem_r} + {1'b0, s1_prod_r[6:0]};
  assign q_delay = s1_prod_r[PROD_W-1:7] + (GAP_WIDTH+1)'(rem_sum[7]);

  // note modulo 12 from low bits of quotient
  assign rmd     = s1_value_r[3:0] - ({s1_quo_r[0], 3'b000} + {s1_quo_r[1:0], 2'b00});
  assign ch8     = s1_chan_r[7:0];
  assign v8      = s1_value_r[7:0];
  assign ch_le7  = (s1_chan_r <= 9'd7);
  assign ch_le10 = (s1_chan_r <= 9'd10);

  always_comb begin
    cmd = '{cnt: 2'd0, b0: 8'd0, b1: 8'd0, b2: 8'd0};
    case (s1_action_r)
      ACT_NOTE_ON: begin
        cmd.cnt = 2'd2;
        cmd.b0  = ch8;
        if (ch_le7) begin
          cmd.b1 = {s1_quo_r[2:0], rmd, 1'b1};
        end else if (ch_le10) begin
          cmd.b1 = {v8[6:0], 1'b0};
        end else begin
          cmd.b1 = v8;
        end
      end
      ACT_NOTE_OFF: begin
        cmd.cnt = 2'd1;
        cmd.b0  = BYTE_NOTE_OFF | ch8;
      end
      ACT_SET_NOTE: begin
        cmd.cnt = 2'd2;
        cmd.b0  = BYTE_SET_CH | ch8;
        cmd.b1  = ch_le7 ? (BYTE_NOTE_HI | {1'b0, s1_quo_r[2:0], rmd})
                         : (BYTE_NOTE_HI | v8);
      end
      ACT_SET_FREQ: begin
        cmd.b0 = BYTE_SET_CH | ch8;
        if (ch_le10) begin
          cmd.cnt = 2'd3;
          cmd.b1  = s1_value_r[15:8];
          cmd.b2  = v8;
        end else begin
          cmd.cnt = 2'd2;
          cmd.b1  = v8;
        end
      end
      ACT_VOLUME: begin
        cmd.cnt = 2'd2;
        cmd.b0  = BYTE_VOLUME | ch8;
        cmd.b1  = v8;
      end
      ACT_PAN: begin
        cmd.cnt = 2'd2;
        cmd.b0  = BYTE_PAN | ch8;
        cmd.b1  = {v8[1:0], 6'd0};
      end
      ACT_INSTR: begin
        cmd.cnt = 2'd2;
        cmd.b0  = BYTE_INSTR | ch8;
        cmd.b1  = v8;
      end
      ACT_REG: begin
        cmd.cnt = 2'd3;
        cmd.b0  = BYTE_REG + {7'd0, s1_chan_r[8]};
        cmd.b1  = ch8;
        cmd.b2  = v8;
      end
      ACT_FLAGS: begin
        cmd.cnt = 2'd2;
        if (s1_chan_r != 9'd0) begin
          cmd.b0 = BYTE_FLAG_SET;
          cmd.b1 = v8;
        end else begin
          cmd.b0 = BYTE_FLAG_CLR;
          cmd.b1 = v8 ^ BYTE_FF;
        end
      end
      ACT_LOCK: begin
        cmd.cnt = 2'd1;
        cmd.b0  = BYTE_LOCK | ch8;
      end
      ACT_LOOP: begin
        cmd.cnt = 2'd1;
        cmd.b0  = BYTE_LOOP;
      end
      ACT_END: begin
        cmd.cnt = 2'd1;
        cmd.b0  = s1_loop_r ? BYTE_END_LOOP : BYTE_FF;
      end
      default: begin
        cmd.cnt = 2'd0;
      end
    endcase
  end

  assign q_push = advance;
  assign q_cmd  = cmd;

endmodule

### src/sebe_queue.sv
// ----------------------------------------------------------------------------
// sebe_queue
// small register queue of encoded event descriptors
// ----------------------------------------------------------------------------
module sebe_queue #(
  parameter int DEPTH = sebe_pkg::QUEUE_DEPTH_DEF,
  parameter int DW    = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          wr_en,
  input  logic [DW-1:0] wr_data,
  output logic          full,
  input  logic          rd_en,
  output logic [DW-1:0] rd_data,
  output logic          empty
);
  import sebe_pkg::*;

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [DW-1:0] mem_r [DEPTH];
  logic [PW-1:0] wptr_r;
  logic [PW-1:0] rptr_r;
  logic [CW-1:0] cnt_r;
  logic          do_wr;
  logic          do_rd;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_wr   = wr_en & ~full;
  assign do_rd   = rd_en & ~empty;
  assign rd_data = mem_r[rptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      if (do_wr) begin
        wptr_r <= (wptr_r == PW'(DEPTH - 1)) ? '0 : wptr_r + PW'(1);
      end
      if (do_rd) begin
        rptr_r <= (rptr_r == PW'(DEPTH - 1)) ? '0 : rptr_r + PW'(1);
      end
      if (do_wr && !do_rd) begin
        cnt_r <= cnt_r + CW'(1);
      end else if (do_rd && !do_wr) begin
        cnt_r <= cnt_r - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

### src/sebe_back.sv
// ----------------------------------------------------------------------------
// sebe_back
// sequences delay and command bytes of one descriptor into the output register
// ----------------------------------------------------------------------------
module sebe_back #(
  parameter int GAP_WIDTH = sebe_pkg::GAP_WIDTH_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                q_empty,
  output logic                q_pop,
  input  logic [GAP_WIDTH:0]  q_delay,
  input  sebe_pkg::sebe_cmd_t q_cmd,
  output logic                out_empty,
  input  logic                out_pop,
  output logic [7:0]          out_byte,
  output logic                out_last
);
  import sebe_pkg::*;

  localparam int DLY_W = GAP_WIDTH + 1;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_SHORT = 5'b00010,
    ST_HI    = 5'b00100,
    ST_LO    = 5'b01000,
    ST_CMD   = 5'b10000
  } sebe_state_t;

  sebe_state_t      state_r, state_nxt;
  logic [DLY_W-1:0] dly_r, dly_nxt;
  sebe_cmd_t        cmd_r, cmd_nxt;
  logic [1:0]       idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [7:0]       out_byte_r, out_byte_nxt;
  logic             out_last_r, out_last_nxt;

  logic             out_ok;
  logic             emit;
  logic [7:0]       emit_byte;
  logic             emit_last;
  logic [7:0]       cmd_sel;
  logic             no_cmd;

  assign out_ok = ~out_valid_r | out_pop;
  assign no_cmd = (cmd_r.cnt == 2'd0);

  always_comb begin
    case (idx_r)
      2'd0:    cmd_sel = cmd_r.b0;
      2'd1:    cmd_sel = cmd_r.b1;
      default: cmd_sel = cmd_r.b2;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    dly_nxt   = dly_r;
    cmd_nxt   = cmd_r;
    idx_nxt   = idx_r;
    q_pop     = 1'b0;
    emit      = 1'b0;
    emit_byte = 8'd0;
    emit_last = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          dly_nxt = q_delay;
          cmd_nxt = q_cmd;
          idx_nxt = 2'd0;
          if (q_delay == '0) begin
            state_nxt = (q_cmd.cnt == 2'd0) ? ST_IDLE : ST_CMD;
          end else if (32'(q_delay) <= 32'(DLY_SHORT_MAX)) begin
            state_nxt = ST_SHORT;
          end else begin
            state_nxt = ST_HI;
          end
        end
      end
      ST_SHORT: begin
        if (out_ok) begin
          emit      = 1'b1;
          emit_byte = BYTE_DLY_SHORT + 8'(dly_r) - 8'd1;
          emit_last = no_cmd;
          state_nxt = no_cmd ? ST_IDLE : ST_CMD;
        end
      end
      ST_HI: begin
        if (out_ok) begin
          emit      = 1'b1;
          emit_byte = BYTE_DLY_LONG;
          state_nxt = ST_LO;
        end
      end
      ST_LO: begin
        if (out_ok) begin
          emit = 1'b1;
          if (32'(dly_r) > 32'(DLY_RUN)) begin
            // full run of 255 ticks
            emit_byte = BYTE_FF;
            dly_nxt   = dly_r - DLY_W'(DLY_RUN);
            if (32'(dly_r) != 32'(DLY_RUN)) begin
              state_nxt = ST_HI;
            end else begin
              state_nxt = no_cmd ? ST_IDLE : ST_CMD;
              emit_last = no_cmd;
            end
          end else begin
            emit_byte = 8'(dly_r);
            emit_last = no_cmd;
            state_nxt = no_cmd ? ST_IDLE : ST_CMD;
          end
        end
      end
      ST_CMD: begin
        if (out_ok) begin
          emit      = 1'b1;
          emit_byte = cmd_sel;
          emit_last = (idx_r == cmd_r.cnt - 2'd1);
          idx_nxt   = idx_r + 2'd1;
          if (emit_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_byte_nxt  = emit_byte;
      out_last_nxt  = emit_last;
    end else if (out_pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dly_r      <= dly_nxt;
    cmd_r      <= cmd_nxt;
    idx_r      <= idx_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_empty = ~out_valid_r;
  assign out_byte  = out_byte_r;
  assign out_last  = out_last_r;

endmodule

### src/sound_event_bytecode_encoder_top.sv
// ----------------------------------------------------------------------------
// path: first byte of an event passes the front stage register, descriptor queue,
//   back end state register and output register on its way to out_byte
// back end pops a descriptor in its idle state, then emits one output byte per cycle while
//   out_pop frees the output register; front takes one per cycle unless the queue is full
// reset (rst_n low, synchronous): queue and output register empty, tempo 128, carried fraction 0, no loop seen
// ----------------------------------------------------------------------------
// sound_event_bytecode_encoder_top
// encodes time-ordered sound events into a delay and command byte stream
// ----------------------------------------------------------------------------
module sound_event_bytecode_encoder_top #(
  parameter int GAP_WIDTH   = sebe_pkg::GAP_WIDTH_DEF,
  parameter int QUEUE_DEPTH = sebe_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // event input, queue style: transaction when in_push and not in_full
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [3:0]           in_action,
  input  logic [GAP_WIDTH-1:0] in_time_gap,
  input  logic [8:0]           in_channel,
  input  logic [15:0]          in_value,
  // byte output, queue style: transaction when out_pop and not out_empty
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import sebe_pkg::*;

  // descriptor carried between front and back: scaled delay plus command bytes
  localparam int DLY_W  = GAP_WIDTH + 1;
  localparam int DESC_W = DLY_W + $bits(sebe_cmd_t);

  logic              fq_push;
  logic              fq_full;
  logic [DLY_W-1:0]  fq_delay;
  sebe_cmd_t         fq_cmd;
  logic              bq_pop;
  logic              bq_empty;
  logic [DESC_W-1:0] bq_desc;

  // front: tempo scaling, fraction carry, note recoding
  sebe_front #(
    .GAP_WIDTH (GAP_WIDTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_full     (in_full),
    .in_action   (in_action),
    .in_time_gap (in_time_gap),
    .in_channel  (in_channel),
    .in_value    (in_value),
    .q_push      (fq_push),
    .q_full      (fq_full),
    .q_delay     (fq_delay),
    .q_cmd       (fq_cmd)
  );

  // descriptor queue lets front keep taking events while bytes drain
  sebe_queue #(
    .DEPTH (QUEUE_DEPTH),
    .DW    (DESC_W)
  ) u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (fq_push),
    .wr_data ({fq_delay, fq_cmd}),
    .full    (fq_full),
    .rd_en   (bq_pop),
    .rd_data (bq_desc),
    .empty   (bq_empty)
  );

  // back: one byte per cycle into the output register while out_pop keeps it free
  sebe_back #(
    .GAP_WIDTH (GAP_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (bq_empty),
    .q_pop     (bq_pop),
    .q_delay   (bq_desc[DESC_W-1:$bits(sebe_cmd_t)]),
    .q_cmd     (sebe_cmd_t'(bq_desc[$bits(sebe_cmd_t)-1:0])),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule
